// ===== rtl/utf8sd_pkg.sv =====
package utf8sd_pkg;

	localparam int CP_W        = 21;
	localparam int LEN_W       = 3;
	localparam int WIN_DEPTH   = 4;
	localparam int WIN_CNT_W   = 3;
	localparam int IN_DEPTH_DEF  = 2;
	localparam int OUT_DEPTH_DEF = 4;

	localparam logic [CP_W-1:0] REPL_RESET  = 21'h00fffd;
	localparam logic [CP_W-1:0] MIN_TWO     = 21'h000080;
	localparam logic [CP_W-1:0] MIN_THREE   = 21'h000800;
	localparam logic [CP_W-1:0] MIN_FOUR    = 21'h010000;
	localparam logic [CP_W-1:0] MAX_FOUR    = 21'h10ffff;
	localparam logic [CP_W-1:0] SURR_LO     = 21'h00d800;
	localparam logic [CP_W-1:0] SURR_HI     = 21'h00dfff;
	localparam logic [CP_W-1:0] NONCHAR_LO  = 21'h00fffe;
	localparam logic [CP_W-1:0] NONCHAR_HI  = 21'h00ffff;

	// byte as it leaves the front: raw value, end flag, lead length (0 = not a lead)
	typedef struct packed {
		logic [7:0]       data;
		logic             eot;
		logic [LEN_W-1:0] len;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
	} win_ent_t;

	typedef struct packed {
		logic [CP_W-1:0]  cp;
		logic             repl;
		logic [LEN_W-1:0] cnt;
		logic             last;
	} res_t;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_REPLAY,
		OP_TRUNC,
		OP_TAKE
	} op_t;

	function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
		logic [LEN_W-1:0] len;
		len = '0;
		priority if (b == 8'h00)
			len = 3'd0;
		else if (b[7] == 1'b0)
			len = 3'd1;
		else if (b[7:6] == 2'b10)
			len = 3'd0;
		else if (b[7:5] == 3'b110)
			len = 3'd2;
		else if (b[7:4] == 4'b1110)
			len = 3'd3;
		else if (b[7:3] == 5'b11110)
			len = 3'd4;
		else
			len = 3'd0;
		return len;
	endfunction

endpackage

// ===== rtl/utf8sd_fifo.sv =====
module utf8sd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/utf8sd_front.sv =====
module utf8sd_front import utf8sd_pkg::*; #(
	parameter int IN_DEPTH = IN_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       full,
	output in_item_t   item,
	output logic       item_valid,
	input  logic       item_pop
);

	in_item_t                     cls;
	logic [$bits(in_item_t)-1:0]  rd_raw;
	logic                         q_empty;

	// lead length is worked out once here; the back keeps it next to the byte
	always_comb begin
		cls.data = in_byte;
		cls.eot  = end_of_text;
		cls.len  = lead_length(in_byte);
	end

	utf8sd_fifo #(
		.WIDTH($bits(in_item_t)),
		.DEPTH(IN_DEPTH)
	) u_in_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls),
		.full    (full),
		.rd_en   (item_pop),
		.rd_data (rd_raw),
		.empty   (q_empty)
	);

	assign item       = in_item_t'(rd_raw);
	assign item_valid = !q_empty;

endmodule

// ===== rtl/utf8sd_back.sv =====
module utf8sd_back import utf8sd_pkg::*; #(
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  in_item_t        item,
	input  logic            item_valid,
	output logic            item_pop,
	input  logic            cfg_we,
	input  logic [CP_W-1:0] cfg_wdata,
	output res_t            res,
	output logic            res_empty,
	input  logic            res_pop
);

	// window: held bytes of the open sequence, then bytes waiting for replay
	win_ent_t               win_q [WIN_DEPTH];
	logic [WIN_CNT_W-1:0]   win_n_q;
	logic [1:0]             held_q;
	logic [LEN_W-1:0]       exp_q;
	logic                   skip_q;
	logic                   fin_q;
	logic [CP_W-1:0]        repl_q;

	res_t                   hold_q;
	logic                   hold_v_q;
	logic                   hold_done_q;

	op_t                    op;
	logic                   take, stall, go;
	win_ent_t               v [WIN_DEPTH];
	win_ent_t               win_nx [WIN_DEPTH];
	win_ent_t               cur;
	logic [WIN_CNT_W-1:0]   n_all, n_nx;
	logic [1:0]             held_nx;
	logic [LEN_W-1:0]       exp_nx;
	logic                   skip_nx, fin_nx;
	logic [2:0]             shift;
	logic                   r_v, step_end;
	res_t                   r;
	logic [5:0]             b1, b2, b3;
	logic [CP_W-1:0]        dec_cp;
	logic                   dec_ok;
	logic                   push, out_full;
	res_t                   push_data;

	always_comb begin
		priority if (win_n_q != {1'b0, held_q})
			op = OP_REPLAY;
		else if (fin_q)
			op = OP_TRUNC;
		else if (item_valid)
			op = OP_TAKE;
		else
			op = OP_IDLE;
	end

	assign stall    = hold_v_q && out_full;
	assign go       = !stall && (op != OP_IDLE);
	assign take     = (op == OP_TAKE);
	assign item_pop = go && take;

	always_comb begin
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (take && win_n_q == WIN_CNT_W'(i)) begin
				v[i].data = item.data;
				v[i].len  = item.len;
			end else begin
				v[i] = win_q[i];
			end
		end
	end

	assign n_all = win_n_q + WIN_CNT_W'(take);
	assign cur   = v[held_q];

	// value of the completed sequence, length taken from exp_q
	always_comb begin
		b1 = v[1].data[5:0];
		b2 = v[2].data[5:0];
		b3 = v[3].data[5:0];
		dec_cp = '0;
		dec_ok = 1'b0;
		unique case (exp_q)
			3'd2: begin
				dec_cp = {10'b0, v[0].data[4:0], b1};
				dec_ok = (dec_cp >= MIN_TWO);
			end
			3'd3: begin
				dec_cp = {5'b0, v[0].data[3:0], b1, b2};
				dec_ok = (dec_cp >= MIN_THREE)
					&& !(dec_cp >= SURR_LO && dec_cp <= SURR_HI)
					&& (dec_cp != NONCHAR_LO) && (dec_cp != NONCHAR_HI);
			end
			3'd4: begin
				dec_cp = {v[0].data[2:0], b1, b2, b3};
				dec_ok = (dec_cp >= MIN_FOUR) && (dec_cp <= MAX_FOUR);
			end
			default: begin
				dec_cp = '0;
				dec_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		logic [2:0] idx;
		held_nx = held_q;
		exp_nx  = exp_q;
		skip_nx = skip_q;
		shift   = '0;
		r_v     = 1'b0;
		r.cp    = repl_q;
		r.repl  = 1'b1;
		r.cnt   = '0;
		r.last  = 1'b0;
		fin_nx  = take ? item.eot : fin_q;

		if (op == OP_TRUNC) begin
			r_v     = 1'b1;
			skip_nx = 1'b1;
			shift   = 3'd1;
			held_nx = '0;
			exp_nx  = '0;
		end else if (held_q == '0) begin
			if (cur.len == '0) begin
				r_v     = !skip_q;
				skip_nx = 1'b1;
				shift   = 3'd1;
			end else begin
				skip_nx = 1'b0;
				if (cur.len == 3'd1) begin
					r_v    = 1'b1;
					r.cp   = {13'b0, cur.data};
					r.repl = 1'b0;
					r.cnt  = 3'd1;
					shift  = 3'd1;
					exp_nx = '0;
				end else begin
					exp_nx  = cur.len;
					held_nx = 2'd1;
				end
			end
		end else if ({1'b0, held_q} + 3'd1 == exp_q) begin
			r_v     = 1'b1;
			held_nx = '0;
			exp_nx  = '0;
			if (dec_ok) begin
				r.cp   = dec_cp;
				r.repl = 1'b0;
				r.cnt  = exp_q;
				shift  = exp_q;
			end else begin
				skip_nx = 1'b1;
				shift   = 3'd1;
			end
		end else begin
			held_nx = held_q + 2'd1;
		end

		n_nx = n_all - shift;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			idx = 3'(i) + shift;
			win_nx[i] = (idx < 3'(WIN_DEPTH)) ? v[idx[1:0]] : v[i];
		end

		// text finished and nothing left open: start the next text clean
		if (fin_nx && n_nx == '0 && held_nx == '0) begin
			fin_nx  = 1'b0;
			skip_nx = 1'b0;
			exp_nx  = '0;
		end
		step_end = (n_nx == {1'b0, held_nx}) && !(fin_nx && held_nx != '0);
	end

	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= win_nx[i];
			end
		end
		if (go && r_v) begin
			hold_q <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_n_q <= '0;
			held_q  <= '0;
			exp_q   <= '0;
			skip_q  <= 1'b0;
			fin_q   <= 1'b0;
			repl_q  <= REPL_RESET;
		end else begin
			if (go) begin
				win_n_q <= n_nx;
				held_q  <= held_nx;
				exp_q   <= exp_nx;
				skip_q  <= skip_nx;
				fin_q   <= fin_nx;
			end
			if (cfg_we) begin
				repl_q <= cfg_wdata;
			end
		end
	end

	// newest result waits in hold until we know whether it closes its byte's run
	assign push = !stall && hold_v_q && ((go && r_v) || hold_done_q);

	always_comb begin
		push_data      = hold_q;
		push_data.last = hold_done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q    <= 1'b0;
			hold_done_q <= 1'b0;
		end else if (!stall) begin
			if (go && r_v) begin
				hold_v_q    <= 1'b1;
				hold_done_q <= step_end;
			end else if (push) begin
				hold_v_q    <= 1'b0;
				hold_done_q <= 1'b0;
			end else if (go && step_end) begin
				hold_done_q <= hold_v_q;
			end
		end
	end

	utf8sd_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_data),
		.full    (out_full),
		.rd_en   (res_pop),
		.rd_data (res),
		.empty   (res_empty)
	);

	a_win_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win_n_q <= WIN_CNT_W'(WIN_DEPTH))
		else $error("window count beyond depth");

	a_held_in_win: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, held_q} <= win_n_q)
		else $error("held bytes exceed window fill");

	a_held_open: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != '0 |-> exp_q > {1'b0, held_q})
		else $error("held bytes without an open sequence");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !out_full)
		else $error("result transfer into a full queue");

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Streaming UTF-8 decoder.
// Input side is a queue: drive in_byte/end_of_text with push; a transfer
// happens on a clock edge with push high and full low. end_of_text marks the
// last byte of a text; after it the decoder starts the next text clean.
// Result side is a queue too: while empty is low the oldest result sits on
// code_point/is_replacement/byte_count/last_of_run and pop takes it.
// last_of_run flags the final result caused by one input byte; a byte may
// cause no result (it opens or continues a sequence) or up to four.
// cfg_we/cfg_wdata write the replacement code; write it only while idle.
// A one-byte character passes through the input queue, the decode
// sequencer, the hold register and the result queue to the result ports.
// Throughput: the decode sequencer handles one byte per cycle while it is
// neither stalled nor replaying; a failed sequence makes it replay the
// trailing bytes before it takes more input, and a sequence cut short at
// end of text adds a truncation step each time.
// If pop stays low the result queue fills, the sequencer stalls, and the
// input queue then raises full. Reset empties both queues, drops any open
// sequence and restores the replacement code to FFFD.
module utf8_stream_decoder import utf8sd_pkg::*; #(
	parameter int IN_DEPTH  = IN_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       in_byte,
	input  logic             end_of_text,
	output logic             empty,
	input  logic             pop,
	output logic [CP_W-1:0]  code_point,
	output logic             is_replacement,
	output logic [LEN_W-1:0] byte_count,
	output logic             last_of_run,
	input  logic             cfg_we,
	input  logic [CP_W-1:0]  cfg_wdata
);

	in_item_t item;
	logic     item_valid, item_pop;
	res_t     res;

	utf8sd_front #(
		.IN_DEPTH(IN_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.full        (full),
		.item        (item),
		.item_valid  (item_valid),
		.item_pop    (item_pop)
	);

	utf8sd_back #(
		.OUT_DEPTH(OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.res        (res),
		.res_empty  (empty),
		.res_pop    (pop)
	);

	assign code_point     = res.cp;
	assign is_replacement = res.repl;
	assign byte_count     = res.cnt;
	assign last_of_run    = res.last;

endmodule
